[hdl/ptns_pkg.sv]
// Shared constants for the point table nearest search block.
package ptns_pkg;

  // Default table depth and coordinate width.
  localparam int unsigned CapacityDef  = 1024;
  localparam int unsigned CoordBitsDef = 16;

  // Fixed field widths.
  localparam int unsigned TagBits    = 16;
  localparam int unsigned OpBits     = 2;
  localparam int unsigned StatusBits = 2;

  // Operation codes.
  localparam logic [OpBits-1:0] OpAdd     = 2'd0;
  localparam logic [OpBits-1:0] OpUpdate  = 2'd1;
  localparam logic [OpBits-1:0] OpNearest = 2'd2;

  // Status codes.
  localparam logic [StatusBits-1:0] StOk      = 2'd0;
  localparam logic [StatusBits-1:0] StFull    = 2'd1;
  localparam logic [StatusBits-1:0] StMissing = 2'd2;
  localparam logic [StatusBits-1:0] StEmpty   = 2'd3;

endpackage

[hdl/ptns_mem.sv]
// Simple dual-port RAM: one write port, one read port, registered read data.
module ptns_mem #(
  parameter int unsigned DEPTH = ptns_pkg::CapacityDef,
  parameter int unsigned WIDTH = 2 * ptns_pkg::CoordBitsDef + ptns_pkg::TagBits
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ptns_dist.sv]
// Three-stage squared distance pipeline: difference, square, sum.
module ptns_dist #(
  parameter int unsigned COORD_BITS = ptns_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [COORD_BITS-1:0]         qx_i,
  input  logic [COORD_BITS-1:0]         qy_i,
  input  logic [COORD_BITS-1:0]         px_i,
  input  logic [COORD_BITS-1:0]         py_i,
  input  logic [ptns_pkg::TagBits-1:0]  tag_i,
  output logic                          vld_o,
  output logic [2*COORD_BITS+1:0]       dist_o,
  output logic [ptns_pkg::TagBits-1:0]  tag_o
);

  localparam int unsigned CB = COORD_BITS;

  logic [2:0]                   vld_q;
  logic signed [CB:0]           dx_q, dy_q;
  logic signed [2*CB+1:0]       prod_x, prod_y;
  logic [2*CB:0]                sqx_q, sqy_q;
  logic [2*CB+1:0]              dist_q;
  logic [ptns_pkg::TagBits-1:0] tag1_q, tag2_q, tag3_q;

  // The square of a difference is never negative, and fits in 2*CB+1 bits.
  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    dx_q   <= $signed({qx_i[CB-1], qx_i}) - $signed({px_i[CB-1], px_i});
    dy_q   <= $signed({qy_i[CB-1], qy_i}) - $signed({py_i[CB-1], py_i});
    tag1_q <= tag_i;
    sqx_q  <= prod_x[2*CB:0];
    sqy_q  <= prod_y[2*CB:0];
    tag2_q <= tag1_q;
    dist_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
    tag3_q <= tag2_q;
  end

  assign vld_o  = vld_q[2];
  assign dist_o = dist_q;
  assign tag_o  = tag3_q;

endmodule

[hdl/point_table_nearest_search.sv]
// Add and unused codes: the word goes straight to the result state once accepted.
// Update: scans the N stored entries in index order, one memory read a cycle.
// Nearest: the single read port walks all entries; an empty table goes
// straight to the result state.
// One word is worked on at a time; a new word is taken while a result waits.
// Reset clears the entry count and control; the point memory is not cleared.
module point_table_nearest_search #(
  parameter int unsigned CAPACITY   = ptns_pkg::CapacityDef,
  parameter int unsigned COORD_BITS = ptns_pkg::CoordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ptns_pkg::OpBits-1:0]      operation_i,
  input  logic [COORD_BITS-1:0]            x_coord_i,
  input  logic [COORD_BITS-1:0]            y_coord_i,
  input  logic [ptns_pkg::TagBits-1:0]     cell_tag_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptns_pkg::StatusBits-1:0]  status_o,
  output logic [ptns_pkg::TagBits-1:0]     nearest_tag_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned TB   = ptns_pkg::TagBits;
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned MemW = 2 * CB + TB;
  localparam int unsigned DW   = 2 * CB + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_NEAR,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]                 count_q, count_d;
  logic [CntW-1:0]                 scan_q, scan_d;
  logic [CntW-1:0]                 done_q, done_d;
  logic [CB-1:0]                   qx_q, qx_d, qy_q, qy_d;
  logic [TB-1:0]                   tag_q, tag_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [AW-1:0]                   rd_idx_q, rd_idx_d;
  logic                            best_vld_q, best_vld_d;
  logic [DW-1:0]                   best_dist_q, best_dist_d;
  logic [TB-1:0]                   best_tag_q, best_tag_d;
  logic [ptns_pkg::StatusBits-1:0] res_status_q, res_status_d;
  logic [TB-1:0]                   res_tag_q, res_tag_d;
  logic                            out_valid_q, out_valid_d;
  logic [ptns_pkg::StatusBits-1:0] out_status_q, out_status_d;
  logic [TB-1:0]                   out_tag_q, out_tag_d;

  logic            in_fire;
  logic            issue_ok;
  logic            take;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [MemW-1:0] mem_wdata, mem_rdata;
  logic [TB-1:0]   rd_tag;
  logic            dist_vld;
  logic [DW-1:0]   dist_val;
  logic [TB-1:0]   dist_tag;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue_ok   = (scan_q < count_q);
  assign rd_tag     = mem_rdata[MemW-1 -: TB];
  assign take       = !best_vld_q || (dist_val < best_dist_q);

  // Point memory, each word holds {tag, y, x}.
  ptns_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (MemW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Distance unit, fed only while a nearest search is running.
  ptns_dist #(
    .COORD_BITS (CB)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q && (state_q == S_NEAR)),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .px_i   (mem_rdata[CB-1:0]),
    .py_i   (mem_rdata[2*CB-1:CB]),
    .tag_i  (rd_tag),
    .vld_o  (dist_vld),
    .dist_o (dist_val),
    .tag_o  (dist_tag)
  );

  // Sequencer. Accesses never overlap on one entry: the only write inside
  // a scan ends it, and an add writes only while no scan is running.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    done_d       = done_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    tag_d        = tag_q;
    best_vld_d   = best_vld_q;
    best_dist_d  = best_dist_q;
    best_tag_d   = best_tag_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = scan_q[AW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = count_q[AW-1:0];
    mem_wdata    = {cell_tag_i, y_coord_i, x_coord_i};
    mem_re       = 1'b0;
    mem_raddr    = scan_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          qx_d         = x_coord_i;
          qy_d         = y_coord_i;
          tag_d        = cell_tag_i;
          scan_d       = '0;
          done_d       = '0;
          best_vld_d   = 1'b0;
          res_status_d = ptns_pkg::StOk;
          res_tag_d    = '0;
          state_d      = S_RESULT;
          case (operation_i)
            ptns_pkg::OpAdd: begin
              if (count_q < CntW'(CAPACITY)) begin
                mem_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                res_status_d = ptns_pkg::StFull;
              end
            end
            ptns_pkg::OpUpdate: begin
              if (count_q == '0) begin
                res_status_d = ptns_pkg::StMissing;
              end else begin
                state_d = S_UPD;
              end
            end
            ptns_pkg::OpNearest: begin
              if (count_q == '0) begin
                res_status_d = ptns_pkg::StEmpty;
              end else begin
                state_d = S_NEAR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_UPD: begin
        if (issue_ok) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          scan_d   = scan_q + CntW'(1);
        end
        // First matching tag in index order gets the new coordinates.
        if (rd_vld_q) begin
          if (rd_tag == tag_q) begin
            mem_we       = 1'b1;
            mem_waddr    = rd_idx_q;
            mem_wdata    = {rd_tag, qy_q, qx_q};
            res_status_d = ptns_pkg::StOk;
            state_d      = S_RESULT;
          end else begin
            done_d = done_q + CntW'(1);
            if (done_q + CntW'(1) == count_q) begin
              res_status_d = ptns_pkg::StMissing;
              state_d      = S_RESULT;
            end
          end
        end
      end

      S_NEAR: begin
        if (issue_ok) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          scan_d   = scan_q + CntW'(1);
        end
        // Strict less-than keeps the lower index on equal distances.
        if (dist_vld) begin
          done_d = done_q + CntW'(1);
          if (take) begin
            best_vld_d  = 1'b1;
            best_dist_d = dist_val;
            best_tag_d  = dist_tag;
          end
          if (done_q + CntW'(1) == count_q) begin
            res_status_d = ptns_pkg::StOk;
            res_tag_d    = take ? dist_tag : best_tag_q;
            state_d      = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_tag_d    = res_tag_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      scan_q       <= '0;
      done_q       <= '0;
      qx_q         <= '0;
      qy_q         <= '0;
      tag_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      best_vld_q   <= 1'b0;
      best_dist_q  <= '0;
      best_tag_q   <= '0;
      res_status_q <= ptns_pkg::StOk;
      res_tag_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ptns_pkg::StOk;
      out_tag_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      done_q       <= done_d;
      qx_q         <= qx_d;
      qy_q         <= qy_d;
      tag_q        <= tag_d;
      rd_vld_q     <= rd_vld_d;
      rd_idx_q     <= rd_idx_d;
      best_vld_q   <= best_vld_d;
      best_dist_q  <= best_dist_d;
      best_tag_q   <= best_tag_d;
      res_status_q <= res_status_d;
      res_tag_q    <= res_tag_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_tag_q    <= out_tag_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign nearest_tag_o = out_tag_q;

  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Memory writes come only from an accepted add or from an update scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_IDLE && in_fire) || state_q == S_UPD))
    else $error("memory write outside add or update");

  // An add with room grows the table by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && operation_i == ptns_pkg::OpAdd && count_q < CntW'(CAPACITY))
      |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("add did not advance entry count");

  // Distances arrive only while a nearest search is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_vld |-> (state_q == S_NEAR))
    else $error("stray distance outside nearest search");

  // A scan never reads past the stored entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (scan_q < count_q))
    else $error("read beyond stored entries");

endmodule
